/* rtl/core/dpcd_pkg.sv */
// ----------------------------------------------------------------------------
// dpcd_pkg
// Shared types and constants for the delta patch command decoder.
// ----------------------------------------------------------------------------
package dpcd_pkg;

   localparam int ADDR_BITS_DEFAULT = 24;

   localparam int BYTE_BITS   = 8;
   localparam int SIZE_BITS   = 24;
   localparam int LEN_BITS    = 16;
   localparam int OFS_BITS    = 16;
   localparam int POS_BITS    = 24;

   // Result queue depth; must be a power of two and at least eight.
   localparam int RSP_DEPTH     = 8;
   localparam int RSP_PTR_BITS  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS  = $clog2(RSP_DEPTH + 1);

   // Register index width on the configuration port.
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [SIZE_BITS-1:0] OLD_SIZE_RESET  = '0;
   localparam logic [SIZE_BITS-1:0] OUT_LIMIT_RESET = '1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_OLD_SIZE  = 1'b0,
      CSR_OUT_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_IDLE = 4'd0,
      PH_LONG = 4'd1,
      PH_MSEL = 4'd2,
      PH_MOFS = 4'd3,
      PH_BIGN = 4'd4,
      PH_SOFS = 4'd5,
      PH_LIT  = 4'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_LITERAL = 2'd0,
      KIND_COPY    = 2'd1,
      KIND_END     = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_SOURCE = 2'd1,
      ERR_LIMIT  = 2'd2,
      ERR_TRUNC  = 2'd3
   } err_type;

   typedef struct packed {
      kind_type               kind;
      logic [BYTE_BITS-1:0]   data_byte;
      logic [SIZE_BITS-1:0]   copy_source;
      logic [LEN_BITS-1:0]    copy_length;
      logic [POS_BITS-1:0]    out_position;
      err_type                error_code;
      logic                   last;
   } rsp_type;

   // Up to two results leave the parser per transaction; a is always first.
   typedef struct packed {
      logic    valid_a;
      logic    valid_b;
      rsp_type a;
      rsp_type b;
   } push_type;

endpackage

/* rtl/core/dpcd_parser.sv */
// ----------------------------------------------------------------------------
// dpcd_parser
// Input register, command parser state and the copy/literal bounds checks.
// ----------------------------------------------------------------------------
module dpcd_parser #(
   parameter int ADDR_BITS = dpcd_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_accept,
   input  logic [dpcd_pkg::BYTE_BITS-1:0] in_byte,
   input  logic                           in_end,
   input  logic [dpcd_pkg::SIZE_BITS-1:0] old_size,
   input  logic [dpcd_pkg::SIZE_BITS-1:0] out_limit,
   output logic                           busy,
   output dpcd_pkg::push_type             push
);
   import dpcd_pkg::*;

   // Compare width: covers the address, the 24-bit sizes, a sign and a carry.
   localparam int CW = ((ADDR_BITS > SIZE_BITS) ? ADDR_BITS : SIZE_BITS) + 2;

   logic                 in_valid_ff;
   logic [BYTE_BITS-1:0] in_byte_ff;
   logic                 in_end_ff;

   phase_type               phase_ff, phase_in, phase_mid;
   logic [1:0]              hc_ff, hc_in, hc_mid;
   logic [BYTE_BITS-1:0]    pend_ff, pend_in, pend_mid;
   logic [SIZE_BITS-1:0]    len_ff, len_in, len_mid;
   logic [OFS_BITS-1:0]     ofs_ff, ofs_in, ofs_mid;
   logic [SIZE_BITS-1:0]    lit_ff, lit_in, lit_mid;
   logic [ADDR_BITS-1:0]    sp_ff, sp_in;
   logic [ADDR_BITS-1:0]    oc_ff, oc_in;
   err_type                 es_ff, es_in;

   logic                    copy_req;
   logic                    lit_req;
   logic [LEN_BITS-1:0]     cp_len;
   logic [OFS_BITS-1:0]     cp_ofs;

   logic [CW-1:0]           src;
   logic [CW-1:0]           src_end;
   logic [CW-1:0]           oc_ext;
   logic [CW-1:0]           oc_sum;
   logic [LEN_BITS-1:0]     step_len;
   logic                    src_bad;
   logic                    over_limit;
   err_type                 item_err;

   logic [ADDR_BITS-1:0]    oc_mid;
   logic [ADDR_BITS-1:0]    sp_mid;
   err_type                 es_mid;
   logic [CW-1:0]           oc_mid_ext;
   rsp_type                 main_res;
   rsp_type                 end_res;
   logic                    main_valid;
   logic                    end_valid;

   assign busy = in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         in_byte_ff <= in_byte;
         in_end_ff  <= in_end;
      end
   end

   // Command decode for the registered byte.
   always_comb begin
      phase_mid = phase_ff;
      hc_mid    = hc_ff;
      pend_mid  = pend_ff;
      len_mid   = len_ff;
      ofs_mid   = ofs_ff;
      lit_mid   = lit_ff;
      copy_req  = 1'b0;
      lit_req   = 1'b0;
      cp_len    = '0;
      cp_ofs    = '0;
      if (in_valid_ff) begin
         unique case (phase_ff)
            PH_IDLE: begin
               hc_mid   = '0;
               len_mid  = '0;
               ofs_mid  = '0;
               pend_mid = in_byte_ff;
               if (in_byte_ff == '0) begin
                  phase_mid = PH_LONG;
               end else if (in_byte_ff[7]) begin
                  phase_mid = (in_byte_ff[6:0] == '0) ? PH_MSEL : PH_SOFS;
               end else begin
                  lit_mid   = {{(SIZE_BITS-7){1'b0}}, in_byte_ff[6:0]};
                  phase_mid = PH_LIT;
               end
            end
            PH_LONG: begin
               case (hc_ff)
                  2'd0: len_mid = {{(SIZE_BITS-8){1'b0}}, in_byte_ff};
                  2'd1: len_mid = {len_ff[23:16], in_byte_ff, len_ff[7:0]};
                  2'd2: ofs_mid = {8'd0, in_byte_ff};
                  default: ofs_mid = {in_byte_ff, ofs_ff[7:0]};
               endcase
               if (hc_ff == 2'd3) begin
                  copy_req  = 1'b1;
                  cp_len    = len_ff[15:0];
                  cp_ofs    = {in_byte_ff, ofs_ff[7:0]};
                  phase_mid = PH_IDLE;
                  hc_mid    = '0;
               end else begin
                  hc_mid = hc_ff + 2'd1;
               end
            end
            PH_MSEL: begin
               hc_mid    = '0;
               len_mid   = {{(SIZE_BITS-8){1'b0}}, in_byte_ff};
               phase_mid = (in_byte_ff == '0) ? PH_BIGN : PH_MOFS;
            end
            PH_MOFS: begin
               if (hc_ff == 2'd0) begin
                  ofs_mid = {8'd0, in_byte_ff};
                  hc_mid  = 2'd1;
               end else begin
                  ofs_mid   = {in_byte_ff, ofs_ff[7:0]};
                  copy_req  = 1'b1;
                  cp_len    = {8'd0, len_ff[7:0]};
                  cp_ofs    = {in_byte_ff, ofs_ff[7:0]};
                  phase_mid = PH_IDLE;
                  hc_mid    = '0;
               end
            end
            PH_BIGN: begin
               case (hc_ff)
                  2'd0: len_mid = {len_ff[23:8], len_ff[7:0] | in_byte_ff};
                  2'd1: len_mid = {len_ff[23:16], len_ff[15:8] | in_byte_ff, len_ff[7:0]};
                  2'd2: len_mid = {len_ff[23:16] | in_byte_ff, len_ff[15:0]};
                  default: len_mid = len_ff;
               endcase
               if (hc_ff[1]) begin
                  lit_mid   = len_mid;
                  phase_mid = (len_mid != '0) ? PH_LIT : PH_IDLE;
                  hc_mid    = '0;
               end else begin
                  hc_mid = hc_ff + 2'd1;
               end
            end
            PH_SOFS: begin
               copy_req  = 1'b1;
               cp_len    = {9'd0, pend_ff[6:0]};
               cp_ofs    = {{8{in_byte_ff[7]}}, in_byte_ff};
               phase_mid = PH_IDLE;
            end
            PH_LIT: begin
               lit_req = 1'b1;
               lit_mid = lit_ff - SIZE_BITS'(1);
               if (lit_mid == '0) begin
                  phase_mid = PH_IDLE;
               end
            end
            default: phase_mid = PH_IDLE;
         endcase
      end
   end

   // Source and output bounds. A literal is checked as a step of one byte.
   always_comb begin
      step_len   = lit_req ? LEN_BITS'(1) : cp_len;
      src        = {{(CW-ADDR_BITS){1'b0}}, sp_ff} + {{(CW-OFS_BITS){cp_ofs[OFS_BITS-1]}}, cp_ofs};
      src_end    = src + {{(CW-LEN_BITS){1'b0}}, cp_len};
      src_bad    = src[CW-1] || (src_end > {{(CW-SIZE_BITS){1'b0}}, old_size});
      oc_ext     = {{(CW-ADDR_BITS){1'b0}}, oc_ff};
      oc_sum     = oc_ext + {{(CW-LEN_BITS){1'b0}}, step_len};
      over_limit = oc_sum > {{(CW-SIZE_BITS){1'b0}}, out_limit};
      if (copy_req && src_bad) begin
         item_err = ERR_SOURCE;
      end else if (over_limit) begin
         item_err = ERR_LIMIT;
      end else begin
         item_err = ERR_NONE;
      end
   end

   // Apply the step, record the first error and close the list on its last byte.
   always_comb begin
      sp_mid = sp_ff;
      oc_mid = oc_ff;
      es_mid = es_ff;
      if (copy_req || lit_req) begin
         if (item_err != ERR_NONE) begin
            if (es_ff == ERR_NONE) begin
               es_mid = item_err;
            end
         end else begin
            oc_mid = oc_sum[ADDR_BITS-1:0];
            if (copy_req) begin
               sp_mid = src_end[ADDR_BITS-1:0];
            end
         end
      end
      oc_mid_ext = {{(CW-ADDR_BITS){1'b0}}, oc_mid};

      main_valid            = copy_req || lit_req;
      main_res.kind         = copy_req ? KIND_COPY : KIND_LITERAL;
      main_res.data_byte    = lit_req ? in_byte_ff : '0;
      main_res.copy_source  = copy_req ? src[SIZE_BITS-1:0] : '0;
      main_res.copy_length  = copy_req ? cp_len : '0;
      main_res.out_position = oc_ext[POS_BITS-1:0];
      main_res.error_code   = item_err;
      main_res.last         = 1'b0;

      end_valid             = in_valid_ff && in_end_ff;
      end_res.kind          = KIND_END;
      end_res.data_byte     = '0;
      end_res.copy_source   = '0;
      end_res.copy_length   = '0;
      end_res.out_position  = oc_mid_ext[POS_BITS-1:0];
      end_res.error_code    = ((es_mid == ERR_NONE) && (phase_mid != PH_IDLE)) ? ERR_TRUNC
                                                                              : es_mid;
      end_res.last          = 1'b1;

      phase_in = phase_mid;
      hc_in    = hc_mid;
      pend_in  = pend_mid;
      len_in   = len_mid;
      ofs_in   = ofs_mid;
      lit_in   = lit_mid;
      sp_in    = sp_mid;
      oc_in    = oc_mid;
      es_in    = es_mid;
      if (end_valid) begin
         phase_in = PH_IDLE;
         hc_in    = '0;
         pend_in  = '0;
         len_in   = '0;
         ofs_in   = '0;
         lit_in   = '0;
         sp_in    = '0;
         oc_in    = '0;
         es_in    = ERR_NONE;
      end

      if (main_valid) begin
         push.valid_a = 1'b1;
         push.a       = main_res;
         push.valid_b = end_valid;
         push.b       = end_res;
      end else begin
         push.valid_a = end_valid;
         push.a       = end_res;
         push.valid_b = 1'b0;
         push.b       = end_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hc_ff    <= '0;
         pend_ff  <= '0;
         len_ff   <= '0;
         ofs_ff   <= '0;
         lit_ff   <= '0;
         sp_ff    <= '0;
         oc_ff    <= '0;
         es_ff    <= ERR_NONE;
      end else begin
         phase_ff <= phase_in;
         hc_ff    <= hc_in;
         pend_ff  <= pend_in;
         len_ff   <= len_in;
         ofs_ff   <= ofs_in;
         lit_ff   <= lit_in;
         sp_ff    <= sp_in;
         oc_ff    <= oc_in;
         es_ff    <= es_in;
      end
   end

endmodule

/* rtl/core/dpcd_rsp_fifo.sv */
// ----------------------------------------------------------------------------
// dpcd_rsp_fifo
// Result queue: takes up to two results per cycle, gives one per cycle on pop.
// ----------------------------------------------------------------------------
module dpcd_rsp_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  dpcd_pkg::push_type                push,
   input  logic                              pop,
   output logic                              out_valid,
   output dpcd_pkg::rsp_type                 out_data,
   output logic [dpcd_pkg::RSP_CNT_BITS-1:0] count
);
   import dpcd_pkg::*;

   rsp_type                 mem_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ff, wr_in;
   logic [RSP_PTR_BITS-1:0] rd_ff, rd_in;
   logic [RSP_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [RSP_PTR_BITS-1:0] wr_next;
   logic [RSP_CNT_BITS-1:0] n_push;
   logic                    do_pop;

   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rd_ff];
   assign count     = cnt_ff;
   assign do_pop    = pop && out_valid;
   assign wr_next   = wr_ff + RSP_PTR_BITS'(1);

   always_comb begin
      n_push = RSP_CNT_BITS'(push.valid_a) + RSP_CNT_BITS'(push.valid_b);
      wr_in  = wr_ff + n_push[RSP_PTR_BITS-1:0];
      rd_in  = do_pop ? rd_ff + RSP_PTR_BITS'(1) : rd_ff;
      cnt_in = cnt_ff + n_push - RSP_CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push.valid_a) begin
         mem_ff[wr_ff] <= push.a;
      end
      if (push.valid_b) begin
         mem_ff[wr_next] <= push.b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* rtl/core/delta_patch_command_decoder_top.sv */
// ----------------------------------------------------------------------------
// delta_patch_command_decoder_top
// Decodes a difference list byte by byte into literal bytes, copy descriptors
// and an end-of-list summary.
//
//   Channel  Direction  Handshake          Carries
//   req_     in         valid / stall      diff_byte, list_end
//   rsp_     out        valid / stall      kind, data_byte, copy_source,
//                                          copy_length, out_position,
//                                          error_code, last
//   csr_     in         valid / ready      index, wdata (old_size, out_limit)
//
// One byte is accepted per cycle while req_stall is low; its results pass
// through the input register, then the parser writes the result queue.
// A byte that closes a command and the list gives two results, which leave
// the eight-entry result queue one after the other.
// req_stall rises only when the queue cannot hold two more results per byte
// in flight. Synchronous reset returns the parser to awaiting an opcode.
// ----------------------------------------------------------------------------
module delta_patch_command_decoder_top #(
   parameter int ADDR_BITS = dpcd_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dpcd_pkg::BYTE_BITS-1:0]      req_diff_byte,
   input  logic                                req_list_end,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_kind,
   output logic [dpcd_pkg::BYTE_BITS-1:0]      rsp_data_byte,
   output logic [dpcd_pkg::SIZE_BITS-1:0]      rsp_copy_source,
   output logic [dpcd_pkg::LEN_BITS-1:0]       rsp_copy_length,
   output logic [dpcd_pkg::POS_BITS-1:0]       rsp_out_position,
   output logic [1:0]                          rsp_error_code,
   output logic                                rsp_last,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dpcd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dpcd_pkg::SIZE_BITS-1:0]      csr_wdata
);
   import dpcd_pkg::*;

   logic [SIZE_BITS-1:0]    old_size_ff, old_size_in;
   logic [SIZE_BITS-1:0]    out_limit_ff, out_limit_in;
   logic                    in_accept;
   logic                    busy;
   push_type                push;
   rsp_type                 head;
   logic [RSP_CNT_BITS-1:0] fifo_count;
   logic [RSP_CNT_BITS:0]   level;

   assign csr_ready = 1'b1;

   always_comb begin
      old_size_in  = old_size_ff;
      out_limit_in = out_limit_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_OLD_SIZE:  old_size_in  = csr_wdata;
            CSR_OUT_LIMIT: out_limit_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         old_size_ff  <= OLD_SIZE_RESET;
         out_limit_ff <= OUT_LIMIT_RESET;
      end else begin
         old_size_ff  <= old_size_in;
         out_limit_ff <= out_limit_in;
      end
   end

   // Room for two results from the byte in the input register and two more
   // from the byte being accepted.
   assign level     = {1'b0, fifo_count} + (busy ? (RSP_CNT_BITS+1)'(2) : '0);
   assign req_stall = level > (RSP_CNT_BITS+1)'(RSP_DEPTH - 2);
   assign in_accept = req_valid && !req_stall;

   dpcd_parser #(
      .ADDR_BITS (ADDR_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .in_byte   (req_diff_byte),
      .in_end    (req_list_end),
      .old_size  (old_size_ff),
      .out_limit (out_limit_ff),
      .busy      (busy),
      .push      (push)
   );

   dpcd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (!rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (head),
      .count     (fifo_count)
   );

   assign rsp_kind         = 2'(head.kind);
   assign rsp_data_byte    = head.data_byte;
   assign rsp_copy_source  = head.copy_source;
   assign rsp_copy_length  = head.copy_length;
   assign rsp_out_position = head.out_position;
   assign rsp_error_code   = 2'(head.error_code);
   assign rsp_last         = head.last;

endmodule

/* tb/sv/delta_patch_command_decoder_checker.sv */
// ----------------------------------------------------------------------------
// delta_patch_command_decoder_checker
// Watches the byte, result and register channels of the decoder. It keeps its
// own copy of the parser state and registers, decodes every accepted byte
// into the results it must cause, and compares each accepted result field by
// field against the oldest outstanding one.
// ----------------------------------------------------------------------------
module delta_patch_command_decoder_checker
   import dpcd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [BYTE_BITS-1:0]      req_diff_byte,
   input  logic                      req_list_end,

   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [1:0]                rsp_kind,
   input  logic [BYTE_BITS-1:0]      rsp_data_byte,
   input  logic [SIZE_BITS-1:0]      rsp_copy_source,
   input  logic [LEN_BITS-1:0]       rsp_copy_length,
   input  logic [POS_BITS-1:0]       rsp_out_position,
   input  logic [1:0]                rsp_error_code,
   input  logic                      rsp_last,

   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [SIZE_BITS-1:0]      csr_wdata,

   output int                        failures,
   output int                        pending_results
);

   timeunit 1ns;
   timeprecision 1ps;

   logic [SIZE_BITS-1:0] old_size_q;
   logic [SIZE_BITS-1:0] out_limit_q;

   phase_type            phase_q;
   logic [1:0]           hdr_cnt;
   logic [7:0]           op_q;
   logic [23:0]          len_acc;
   logic [15:0]          ofs_acc;
   logic [23:0]          lit_left;
   logic [23:0]          src_pos;
   logic [23:0]          out_cnt;
   err_type              first_err;

   rsp_type              decoded_results[$];
   rsp_type              want_rsp;
   int                   fail_total = 0;

   assign failures = fail_total;

   function automatic void clear_list_state();
      phase_q   = PH_IDLE;
      hdr_cnt   = '0;
      op_q      = '0;
      len_acc   = '0;
      ofs_acc   = '0;
      lit_left  = '0;
      src_pos   = '0;
      out_cnt   = '0;
      first_err = ERR_NONE;
   endfunction

   function automatic void note_error(input err_type e);
      if (first_err == ERR_NONE) begin
         first_err = e;
      end
   endfunction

   // A copy that fails a check is reported but leaves the pointers alone.
   function automatic void emit_copy(input logic [15:0] len, input longint ofs);
      longint  src;
      err_type err;
      rsp_type r;
      src = longint'(src_pos) + ofs;
      if (src < 0 || src + longint'(len) > longint'(old_size_q)) begin
         err = ERR_SOURCE;
      end else if (longint'(out_cnt) + longint'(len) > longint'(out_limit_q)) begin
         err = ERR_LIMIT;
      end else begin
         err = ERR_NONE;
      end
      r              = '0;
      r.kind         = KIND_COPY;
      r.copy_source  = src[23:0];
      r.copy_length  = len;
      r.out_position = out_cnt;
      r.error_code   = err;
      decoded_results.push_back(r);
      if (err != ERR_NONE) begin
         note_error(err);
      end else begin
         src_pos = src[23:0] + len;
         out_cnt = out_cnt + len;
      end
   endfunction

   function automatic void decode_diff_byte(input logic [7:0] b, input logic list_end);
      rsp_type r;
      case (phase_q)
         PH_IDLE: begin
            hdr_cnt = '0;
            len_acc = '0;
            ofs_acc = '0;
            op_q    = b;
            if (b == 8'h00) begin
               phase_q = PH_LONG;
            end else if (b[7]) begin
               phase_q = (b[6:0] == 7'd0) ? PH_MSEL : PH_SOFS;
            end else begin
               lit_left = {17'd0, b[6:0]};
               phase_q  = PH_LIT;
            end
         end
         PH_LONG: begin
            case (hdr_cnt)
               2'd0:    len_acc = {16'd0, b};
               2'd1:    len_acc[15:8] = b;
               2'd2:    ofs_acc = {8'd0, b};
               default: ofs_acc[15:8] = b;
            endcase
            if (hdr_cnt == 2'd3) begin
               emit_copy(len_acc[15:0], longint'($signed(ofs_acc)));
               phase_q = PH_IDLE;
               hdr_cnt = '0;
            end else begin
               hdr_cnt++;
            end
         end
         PH_MSEL: begin
            hdr_cnt = '0;
            len_acc = {16'd0, b};
            phase_q = (b == 8'h00) ? PH_BIGN : PH_MOFS;
         end
         PH_MOFS: begin
            if (hdr_cnt == 2'd0) begin
               ofs_acc = {8'd0, b};
               hdr_cnt = 2'd1;
            end else begin
               ofs_acc[15:8] = b;
               emit_copy({8'd0, len_acc[7:0]}, longint'($signed(ofs_acc)));
               phase_q = PH_IDLE;
               hdr_cnt = '0;
            end
         end
         PH_BIGN: begin
            len_acc = len_acc | (24'(b) << (8 * hdr_cnt));
            if (hdr_cnt >= 2'd2) begin
               lit_left = len_acc;
               phase_q  = (lit_left != 24'd0) ? PH_LIT : PH_IDLE;
               hdr_cnt  = '0;
            end else begin
               hdr_cnt++;
            end
         end
         PH_SOFS: begin
            emit_copy({9'd0, op_q[6:0]}, longint'($signed(b)));
            phase_q = PH_IDLE;
         end
         PH_LIT: begin
            r              = '0;
            r.kind         = KIND_LITERAL;
            r.data_byte    = b;
            r.out_position = out_cnt;
            if ({1'b0, out_cnt} + 25'd1 > {1'b0, out_limit_q}) begin
               r.error_code = ERR_LIMIT;
               note_error(ERR_LIMIT);
            end else begin
               r.error_code = ERR_NONE;
               out_cnt++;
            end
            decoded_results.push_back(r);
            lit_left--;
            if (lit_left == 24'd0) begin
               phase_q = PH_IDLE;
            end
         end
         default: phase_q = PH_IDLE;
      endcase

      if (list_end) begin
         if (phase_q != PH_IDLE) begin
            note_error(ERR_TRUNC);
         end
         r              = '0;
         r.kind         = KIND_END;
         r.out_position = out_cnt;
         r.error_code   = first_err;
         r.last         = 1'b1;
         decoded_results.push_back(r);
         clear_list_state();
      end
   endfunction

   function automatic void check_field(input string name, input logic [23:0] want,
                                       input logic [23:0] got);
      if (want !== got) begin
         fail_total++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         old_size_q  = OLD_SIZE_RESET;
         out_limit_q = OUT_LIMIT_RESET;
         clear_list_state();
         decoded_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_OLD_SIZE:  old_size_q  = csr_wdata;
               CSR_OUT_LIMIT: out_limit_q = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            decode_diff_byte(req_diff_byte, req_list_end);
         end
         if (rsp_valid && !rsp_stall) begin
            if (decoded_results.size() == 0) begin
               fail_total++;
               $display("%0t: unexpected result, expected none, actual kind %0d",
                        $time, rsp_kind);
            end else begin
               want_rsp = decoded_results.pop_front();
               check_field("kind", want_rsp.kind, rsp_kind);
               check_field("data_byte", want_rsp.data_byte, rsp_data_byte);
               check_field("copy_source", want_rsp.copy_source, rsp_copy_source);
               check_field("copy_length", want_rsp.copy_length, rsp_copy_length);
               check_field("out_position", want_rsp.out_position, rsp_out_position);
               check_field("error_code", want_rsp.error_code, rsp_error_code);
               check_field("last", want_rsp.last, rsp_last);
            end
         end
      end
      pending_results <= decoded_results.size();
   end

endmodule

/* tb/sv/delta_patch_command_decoder_top_tb.sv */
// ----------------------------------------------------------------------------
// delta_patch_command_decoder_top_tb
// Drives difference lists into the decoder: a short directed part covering
// every command form and error, then random lists, mostly well formed, under
// several register settings and three idling patterns, with one long result
// hold-off. The checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module delta_patch_command_decoder_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import dpcd_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 400;
   localparam int BLOCK_ITEMS  = 106;

   logic                 clock;
   logic                 reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [BYTE_BITS-1:0] req_diff_byte = '0;
   logic                 req_list_end = 1'b0;

   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_kind;
   logic [BYTE_BITS-1:0] rsp_data_byte;
   logic [SIZE_BITS-1:0] rsp_copy_source;
   logic [LEN_BITS-1:0]  rsp_copy_length;
   logic [POS_BITS-1:0]  rsp_out_position;
   logic [1:0]           rsp_error_code;
   logic                 rsp_last;

   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   csr_index_type        csr_index = CSR_OLD_SIZE;
   logic [SIZE_BITS-1:0] csr_wdata = '0;

   int                   fail_count;
   int                   pending_results;
   int                   items_sent = 0;
   int                   cycle_count = 0;
   int                   send_idle_pct = 10;
   int                   rcv_stall_pct = 72;
   logic                 pressure_on = 1'b0;
   logic                 pressure_done = 1'b0;

   delta_patch_command_decoder_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_diff_byte    (req_diff_byte),
      .req_list_end     (req_list_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_copy_source  (rsp_copy_source),
      .rsp_copy_length  (rsp_copy_length),
      .rsp_out_position (rsp_out_position),
      .rsp_error_code   (rsp_error_code),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   delta_patch_command_decoder_checker result_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_diff_byte    (req_diff_byte),
      .req_list_end     (req_list_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_copy_source  (rsp_copy_source),
      .rsp_copy_length  (rsp_copy_length),
      .rsp_out_position (rsp_out_position),
      .rsp_error_code   (rsp_error_code),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .failures         (fail_count),
      .pending_results  (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result side. The one long hold-off lets the result queue fill up so that
   // the block has to stall its byte input.
   initial begin
      forever begin
         @(posedge clock);
         if (pressure_on && !pressure_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            pressure_done = 1'b1;
         end
         rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic list_end);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_diff_byte <= b;
      req_list_end  <= list_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_list(input logic [7:0] bytes[$]);
      foreach (bytes[i]) begin
         send_byte(bytes[i], i == bytes.size() - 1);
      end
   endtask

   // Both registers go in back to back so valid is lowered only once.
   task automatic write_config(input logic [23:0] old_size, input logic [23:0] out_limit);
      csr_valid <= 1'b1;
      csr_index <= CSR_OLD_SIZE;
      csr_wdata <= old_size;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_OUT_LIMIT;
      csr_wdata <= out_limit;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input int k);
      case (k)
         0:       write_config(24'hFFFFFF, 24'hFFFFFF);
         1:       write_config(24'h000000, 24'hFFFFFF);
         2:       write_config(24'h000800, 24'h000000);
         3:       write_config(24'($urandom_range(24'h010000, 24'hFFFFFF)),
                               24'($urandom_range(20, 600)));
         4:       write_config(24'($urandom_range(0, 24'h00FFFF)), 24'($urandom()));
         default: write_config(24'($urandom()), 24'($urandom_range(200, 4000)));
      endcase
   endtask

   // Offsets stay mostly near zero so that many copies land inside the block.
   function automatic logic [15:0] random_offset();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         return 16'($urandom_range(0, 200));
      end else if (pick < 85) begin
         return 16'(-$urandom_range(1, 200));
      end
      return 16'($urandom());
   endfunction

   // A list longer than the bytes left in the block is cut, and may end mid-command.
   task automatic send_random_list(input int budget);
      logic [7:0]  bytes[$];
      logic [15:0] v;
      int          n_cmds;
      int          count;
      int          cut;
      if ($urandom_range(99) < 8) begin
         count = $urandom_range(1, 12);
         repeat (count) bytes.push_back(8'($urandom()));
      end else begin
         n_cmds = $urandom_range(1, 6);
         repeat (n_cmds) begin
            case ($urandom_range(0, 4))
               0: begin
                  v = ($urandom_range(99) < 80) ? 16'($urandom_range(0, 64))
                                                : 16'($urandom());
                  bytes.push_back(8'h00);
                  bytes.push_back(v[7:0]);
                  bytes.push_back(v[15:8]);
                  v = random_offset();
                  bytes.push_back(v[7:0]);
                  bytes.push_back(v[15:8]);
               end
               1: begin
                  v = random_offset();
                  bytes.push_back(8'h80);
                  bytes.push_back(8'($urandom_range(1, 255)));
                  bytes.push_back(v[7:0]);
                  bytes.push_back(v[15:8]);
               end
               2: begin
                  bytes.push_back(8'h80 | 8'($urandom_range(1, 127)));
                  bytes.push_back(8'($urandom()));
               end
               3: begin
                  count = ($urandom_range(99) < 75) ? $urandom_range(1, 8)
                                                    : $urandom_range(1, 127);
                  bytes.push_back(8'(count));
                  repeat (count) bytes.push_back(8'($urandom()));
               end
               default: begin
                  count = ($urandom_range(99) < 80) ? $urandom_range(0, 20)
                                                    : $urandom_range(0, 300);
                  bytes.push_back(8'h80);
                  bytes.push_back(8'h00);
                  bytes.push_back(count[7:0]);
                  bytes.push_back(count[15:8]);
                  bytes.push_back(count[23:16]);
                  repeat (count) bytes.push_back(8'($urandom()));
               end
            endcase
         end
         // Some lists end in the middle of a command.
         if ($urandom_range(99) < 10 && bytes.size() > 1) begin
            cut = $urandom_range(1, bytes.size() - 1);
            while (bytes.size() > cut) void'(bytes.pop_back());
         end
      end
      while (bytes.size() > budget) void'(bytes.pop_back());
      send_list(bytes);
   endtask

   initial begin
      int idle_round;
      int setting;
      int block_end;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Literal run, long copy, medium copy, short copy out of the block,
      // empty big literal, and a zero-length long copy closing the list.
      write_config(24'h001000, 24'hFFFFFF);
      send_list('{8'h02, 8'hAA, 8'hFF,
                  8'h00, 8'h10, 8'h00, 8'h20, 8'h00,
                  8'h80, 8'h04, 8'hF0, 8'hFF,
                  8'hFF, 8'h80,
                  8'h80, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      // A medium copy cut short by the end of the list.
      send_list('{8'h80, 8'h01});
      settle();
      // Literal bytes beyond a one-byte output limit.
      write_config(24'h001000, 24'h000001);
      send_list('{8'h03, 8'h11, 8'h22, 8'h33});

      for (idle_round = 0; idle_round < 3; idle_round++) begin
         case (idle_round)
            0: begin
               send_idle_pct = 10;
               rcv_stall_pct = 72;
            end
            1: begin
               send_idle_pct = 72;
               rcv_stall_pct = 10;
            end
            default: begin
               send_idle_pct = 0;
               rcv_stall_pct = 0;
            end
         endcase
         for (setting = 0; setting < 6; setting++) begin
            settle();
            apply_setting(setting);
            if (idle_round == 2 && setting == 0) begin
               pressure_on = 1'b1;
            end
            block_end = items_sent + BLOCK_ITEMS;
            while (items_sent < block_end) send_random_list(block_end - items_sent);
         end
      end

      settle();
      if (fail_count == 0 && pending_results == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
